// File: design/hte_pkg.sv
`default_nettype none
package hte_pkg;

  // character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // offset from the low nibble of a hex letter to its digit value
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  // result kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // one queued job: an optional byte result followed by an optional count report
  typedef struct packed {
    logic       has_byte;
    logic [7:0] byte_value;
    logic [6:0] byte_index;
    logic       has_count;
    logic [7:0] total_count;
    logic       overflow;
  } job_t;

endpackage
`default_nettype wire

// File: design/hex_text_byte_extractor.sv
// A character that yields a result goes into the job queue and then into the output register.
// The front takes one character per cycle while the queue is not full, updating the parser
// state on each accepted character. A character that gives both a byte and the end count
// fills the output register twice, the byte first and then the count; the back end issues
// one result per cycle while out_ready is high.
// Reset (rst, synchronous): parser state idle, index 1, queue and output register empty.
`default_nettype none
module hex_text_byte_extractor #(
  parameter int TABLE_SIZE  = 128,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [7:0]  text_char,
  input  wire        first_char,
  input  wire        last_char,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       result_kind,
  output logic [7:0] byte_value,
  output logic [6:0] byte_index,
  output logic [7:0] total_count,
  output logic       overflow,
  output logic       last_result
);

  logic          accept;
  logic          push;
  hte_pkg::job_t job;
  logic          full;
  logic          empty;
  logic          pop;
  hte_pkg::job_t head;

  // the front takes a transaction whenever the queue has room, even while the
  // output register is stalled
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // front: character classification and parser state; pushes only characters
  // that produce at least one result
  hte_front #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_char (text_char),
    .first_char(first_char),
    .last_char (last_char),
    .push      (push),
    .job       (job)
  );

  // short job queue decoupling the parser from the output side
  hte_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  // back: expands each job into one or two output transactions
  hte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_kind(result_kind),
    .byte_value (byte_value),
    .byte_index (byte_index),
    .total_count(total_count),
    .overflow   (overflow),
    .last_result(last_result)
  );

endmodule
`default_nettype wire

// File: design/hte_fifo.sv
`default_nettype none
module hte_fifo #(
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  hte_pkg::job_t    push_data,
  output logic             full,
  input  wire              pop,
  output logic             empty,
  output hte_pkg::job_t    head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hte_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/hte_front.sv
`default_nettype none
module hte_front #(
  parameter int TABLE_SIZE = 128
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            accept,
  input  wire [7:0]      text_char,
  input  wire            first_char,
  input  wire            last_char,
  output logic           push,
  output hte_pkg::job_t  job
);

  localparam int IDX_W = $clog2(TABLE_SIZE + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ZERO,
    PH_X,
    PH_HIGH
  } phase_t;

  localparam logic [1:0] SL_NONE    = 2'd0;
  localparam logic [1:0] SL_ONE     = 2'd1;
  localparam logic [1:0] SL_COMMENT = 2'd2;

  phase_t           digit_phase;
  logic [1:0]       slash_level;
  logic [3:0]       high_nibble;
  logic [IDX_W-1:0] next_index;
  logic             dropped_flag;

  phase_t           digit_phase_next;
  logic [1:0]       slash_level_next;
  logic [3:0]       high_nibble_next;
  logic [IDX_W-1:0] next_index_next;
  logic             dropped_flag_next;

  phase_t           base_phase;
  logic [1:0]       base_slash;
  logic [3:0]       base_high;
  logic [IDX_W-1:0] base_index;
  logic             base_dropped;

  logic             is_digit;
  logic             is_lower_hex;
  logic             is_upper_hex;
  logic             is_hex;
  logic [3:0]       digit;
  logic             have_byte;
  logic [IDX_W+7:0] idx_ext;
  logic [IDX_W+7:0] cnt_ext;

  always_comb begin
    // first character of a text starts from the reset state
    base_phase   = first_char ? PH_IDLE : digit_phase;
    base_slash   = first_char ? SL_NONE : slash_level;
    base_high    = first_char ? 4'd0 : high_nibble;
    base_index   = first_char ? IDX_W'(1) : next_index;
    base_dropped = first_char ? 1'b0 : dropped_flag;

    is_digit     = (text_char >= hte_pkg::CH_ZERO) && (text_char <= hte_pkg::CH_NINE);
    is_lower_hex = (text_char >= hte_pkg::CH_LOW_A) && (text_char <= hte_pkg::CH_LOW_F);
    is_upper_hex = (text_char >= hte_pkg::CH_UP_A) && (text_char <= hte_pkg::CH_UP_F);
    is_hex       = is_digit || is_lower_hex || is_upper_hex;
    digit        = is_digit ? text_char[3:0] : text_char[3:0] + hte_pkg::HEX_LETTER_OFS;

    digit_phase_next  = base_phase;
    slash_level_next  = base_slash;
    high_nibble_next  = base_high;
    next_index_next   = base_index;
    dropped_flag_next = base_dropped;
    have_byte         = 1'b0;

    if (text_char == hte_pkg::CH_CR || text_char == hte_pkg::CH_LF) begin
      slash_level_next = SL_NONE;
      digit_phase_next = PH_IDLE;
    end else if (text_char == hte_pkg::CH_SLASH) begin
      if (base_slash != SL_COMMENT) begin
        slash_level_next = base_slash + 1'b1;
      end
      digit_phase_next = PH_IDLE;
    end else if (is_hex) begin
      if (base_slash != SL_COMMENT) begin
        if (is_digit && base_phase == PH_IDLE && text_char == hte_pkg::CH_ZERO) begin
          digit_phase_next = PH_ZERO;
        end else if (base_phase == PH_X) begin
          digit_phase_next = PH_HIGH;
          high_nibble_next = digit;
        end else if (base_phase == PH_HIGH) begin
          digit_phase_next = PH_IDLE;
          if (base_index < IDX_W'(TABLE_SIZE)) begin
            have_byte       = 1'b1;
            next_index_next = base_index + 1'b1;
          end else begin
            dropped_flag_next = 1'b1;
          end
        end
      end
    end else if (text_char == hte_pkg::CH_LOW_X || text_char == hte_pkg::CH_UP_X) begin
      if (base_phase == PH_ZERO) begin
        digit_phase_next = PH_X;
      end
    end else begin
      if (base_slash == SL_ONE) begin
        slash_level_next = SL_NONE;
      end
      digit_phase_next = PH_IDLE;
    end

    // indices wrap to the port widths
    idx_ext = {8'd0, base_index};
    cnt_ext = {8'd0, next_index_next};

    job.has_byte    = have_byte;
    job.byte_value  = {base_high, digit};
    job.byte_index  = idx_ext[6:0];
    job.has_count   = last_char;
    job.total_count = cnt_ext[7:0];
    job.overflow    = dropped_flag_next;

    push = accept && (have_byte || last_char);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_phase  <= PH_IDLE;
      slash_level  <= SL_NONE;
      high_nibble  <= 4'd0;
      next_index   <= IDX_W'(1);
      dropped_flag <= 1'b0;
    end else if (accept) begin
      digit_phase  <= digit_phase_next;
      slash_level  <= slash_level_next;
      high_nibble  <= high_nibble_next;
      next_index   <= next_index_next;
      dropped_flag <= dropped_flag_next;
    end
  end

endmodule
`default_nettype wire

// File: design/hte_back.sv
`default_nettype none
module hte_back (
  input  wire            clk,
  input  wire            rst,
  input  wire            empty,
  input  hte_pkg::job_t  head,
  output logic           pop,
  output logic           out_valid,
  input  wire            out_ready,
  output logic           result_kind,
  output logic [7:0]     byte_value,
  output logic [6:0]     byte_index,
  output logic [7:0]     total_count,
  output logic           overflow,
  output logic           last_result
);

  logic       load_ok;
  logic       pend_count;
  logic [7:0] pend_total;
  logic       pend_ovf;

  assign load_ok = !out_valid || out_ready;
  assign pop     = load_ok && !pend_count && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_count <= 1'b0;
    end else if (load_ok) begin
      if (pend_count) begin
        out_valid  <= 1'b1;
        pend_count <= 1'b0;
      end else if (!empty) begin
        out_valid  <= 1'b1;
        pend_count <= head.has_byte && head.has_count;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (pend_count) begin
        result_kind <= hte_pkg::KIND_COUNT;
        byte_value  <= 8'd0;
        byte_index  <= 7'd0;
        total_count <= pend_total;
        overflow    <= pend_ovf;
        last_result <= 1'b1;
      end else if (!empty) begin
        pend_total <= head.total_count;
        pend_ovf   <= head.overflow;
        if (head.has_byte) begin
          result_kind <= hte_pkg::KIND_BYTE;
          byte_value  <= head.byte_value;
          byte_index  <= head.byte_index;
          total_count <= 8'd0;
          overflow    <= 1'b0;
          last_result <= !head.has_count;
        end else begin
          result_kind <= hte_pkg::KIND_COUNT;
          byte_value  <= 8'd0;
          byte_index  <= 7'd0;
          total_count <= head.total_count;
          overflow    <= head.overflow;
          last_result <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_hex_text_byte_extractor.sv
module tb_hex_text_byte_extractor;

  // Must track the DUT default: the table capacity sets where bytes start dropping.
  localparam int TABLE_SIZE   = 128;
  localparam int ITEMS_TARGET = 1200;
  // Cycles with no transaction on either side before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;

  localparam logic [7:0] CH_SPACE = 8'h20;

  // One output transaction, laid out like the result ports.
  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [6:0] index;
    logic [7:0] total;
    logic       ovf;
    logic       last;
  } ext_result_t;

  localparam ext_result_t NO_RESULT = '0;

  // One input transaction.
  typedef struct {
    logic [7:0] c;
    bit         f;
    bit         l;
  } char_item_t;

  // Directed script row. ntyped > 0 means the expected results are written out
  // in the row itself; ntyped == 0 leaves them to the parser model below.
  typedef struct {
    logic [7:0]  c;
    bit          f;
    bit          l;
    int          ntyped;
    ext_result_t e0;
    ext_result_t e1;
  } script_row_t;

  typedef enum logic [1:0] {PH_IDLE, PH_ZERO, PH_X, PH_HIGH} phase_t;
  typedef enum logic [1:0] {SL_NONE, SL_ONE, SL_COMMENT} slash_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_char = '0;
  logic       first_char = 1'b0;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       result_kind;
  logic [7:0] byte_value;
  logic [6:0] byte_index;
  logic [7:0] total_count;
  logic       overflow;
  logic       last_result;

  hex_text_byte_extractor u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_char  (text_char),
    .first_char (first_char),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_kind(result_kind),
    .byte_value (byte_value),
    .byte_index (byte_index),
    .total_count(total_count),
    .overflow   (overflow),
    .last_result(last_result)
  );

  always #2 clk = ~clk;

  // Parser model state, same reset values as the block.
  phase_t      ph       = PH_IDLE;
  slash_t      sl       = SL_NONE;
  logic [3:0]  hi_nib   = '0;
  int unsigned next_idx = 1;
  bit          dropped  = 1'b0;

  ext_result_t char_results[$];  // results of the character just parsed
  ext_result_t due_results[$];   // results still owed by the DUT, oldest first
  char_item_t  text_q[$];        // random text being built
  int          errors = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  bit          steady_run = 1'b0; // both sides run without gaps while set

  // Directed text. Covers both byte extremes, 0x/0X, lower and upper hex,
  // digits after a lone slash, a comment with a 0x prefix in it, LF ending
  // the comment, stray digit and hex letter in the idle phase, and a last
  // character that yields a byte plus the count report.
  script_row_t script [25] = '{
    '{hte_pkg::CH_ZERO,  1'b1, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_LOW_X, 1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_UP_F,  1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_LOW_F, 1'b0, 1'b0, 1,
      '{hte_pkg::KIND_BYTE, 8'hFF, 7'd1, 8'd0, 1'b0, 1'b1}, NO_RESULT},
    '{hte_pkg::CH_ZERO,  1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_UP_X,  1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_ZERO,  1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_ZERO,  1'b0, 1'b0, 1,
      '{hte_pkg::KIND_BYTE, 8'h00, 7'd2, 8'd0, 1'b0, 1'b1}, NO_RESULT},
    '{hte_pkg::CH_SLASH, 1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_ZERO,  1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_LOW_X, 1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_NINE,  1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_LOW_A, 1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{CH_SPACE,          1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_SLASH, 1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_SLASH, 1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_ZERO,  1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_LOW_X, 1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_LF,    1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{"5",               1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_UP_A,  1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_ZERO,  1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{hte_pkg::CH_UP_X,  1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{"1",               1'b0, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{"2",               1'b0, 1'b1, 2,
      '{hte_pkg::KIND_BYTE, 8'h12, 7'd4, 8'd0, 1'b0, 1'b0},
      '{hte_pkg::KIND_COUNT, 8'h00, 7'd0, 8'd5, 1'b0, 1'b1}}
  };

  // Parser model: advance the state by one character and leave its results
  // in char_results.
  function automatic void parse_char(logic [7:0] c, bit f, bit l);
    bit          is_num;
    bit          is_hex;
    bit          have_byte;
    logic [3:0]  nib;
    logic [7:0]  value;
    ext_result_t r;
    char_results.delete();
    have_byte = 1'b0;
    value = '0;
    if (f) begin
      ph = PH_IDLE;
      sl = SL_NONE;
      hi_nib = '0;
      next_idx = 1;
      dropped = 1'b0;
    end
    is_num = (c >= hte_pkg::CH_ZERO) && (c <= hte_pkg::CH_NINE);
    is_hex = ((c >= hte_pkg::CH_LOW_A) && (c <= hte_pkg::CH_LOW_F)) ||
             ((c >= hte_pkg::CH_UP_A) && (c <= hte_pkg::CH_UP_F));
    // folding to lower case makes both letter ranges start at 'a'
    nib = is_num ? 4'(c - hte_pkg::CH_ZERO)
                 : 4'((c | 8'h20) - hte_pkg::CH_LOW_A + 8'd10);

    if (c == hte_pkg::CH_CR || c == hte_pkg::CH_LF) begin
      sl = SL_NONE;
      ph = PH_IDLE;
    end else if (c == hte_pkg::CH_SLASH) begin
      if (sl != SL_COMMENT) sl = slash_t'(sl + 2'd1);
      ph = PH_IDLE;
    end else if (is_num || is_hex) begin
      // digits never cancel a lone slash, and are dead inside a comment
      if (sl != SL_COMMENT) begin
        if (is_num && ph == PH_IDLE && c == hte_pkg::CH_ZERO) begin
          ph = PH_ZERO;
        end else if (ph == PH_X) begin
          ph = PH_HIGH;
          hi_nib = nib;
        end else if (ph == PH_HIGH) begin
          ph = PH_IDLE;
          if (next_idx < TABLE_SIZE) begin
            have_byte = 1'b1;
            value = {hi_nib, nib};
          end else begin
            dropped = 1'b1;
          end
        end
      end
    end else if (c == hte_pkg::CH_LOW_X || c == hte_pkg::CH_UP_X) begin
      // advances after a '0' even in a comment; leaves the slash count alone
      if (ph == PH_ZERO) ph = PH_X;
    end else begin
      if (sl == SL_ONE) sl = SL_NONE;
      ph = PH_IDLE;
    end

    if (have_byte) begin
      r = '{hte_pkg::KIND_BYTE, value, 7'(next_idx), 8'd0, 1'b0, !l};
      char_results.push_back(r);
      next_idx++;
    end
    if (l) begin
      r = '{hte_pkg::KIND_COUNT, 8'd0, 7'd0, 8'(next_idx), dropped, 1'b1};
      char_results.push_back(r);
    end
  endfunction

  function automatic int pause_len();
    return steady_run ? 0 : $urandom_range(0, 8);
  endfunction

  // Drive one character and hold it until the DUT takes it. Called at a rising
  // edge; returns at the edge of the transaction. With use_model clear the
  // caller supplies the expected results itself.
  task automatic send_char(logic [7:0] c, bit f, bit l, bit use_model);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // gap == 0 keeps valid high straight into the next transaction
    in_valid   <= 1'b1;
    text_char  <= c;
    first_char <= f;
    last_char  <= l;
    do @(posedge clk); while (!in_ready);
    parse_char(c, f, l);
    if (use_model) begin
      foreach (char_results[i]) due_results.push_back(char_results[i]);
    end
    items_sent++;
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic void add_ch(logic [7:0] c);
    char_item_t it;
    it.c = c;
    it.f = 1'b0;
    it.l = 1'b0;
    text_q.push_back(it);
  endfunction

  function automatic logic [7:0] hex_ch();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return hte_pkg::CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? hte_pkg::CH_LOW_A : hte_pkg::CH_UP_A) + 8'(v - 10);
  endfunction

  // "0x" + two hex digits, cut short after upto characters
  function automatic void add_byte_seq(int upto);
    add_ch(hte_pkg::CH_ZERO);
    if (upto > 1) add_ch($urandom_range(0, 1) ? hte_pkg::CH_LOW_X : hte_pkg::CH_UP_X);
    if (upto > 2) add_ch(hex_ch());
    if (upto > 3) add_ch(hex_ch());
  endfunction

  // Random text: mostly well-formed bytes, mixed with cut-off bytes, lone
  // slashes, comments, line ends and raw noise. A dense text is nothing but
  // bytes, enough of them to fill the table and drop a few.
  task automatic build_text(bit dense);
    int         ntok;
    int         kind;
    logic [7:0] c;
    text_q.delete();
    ntok = dense ? TABLE_SIZE + 3 : $urandom_range(1, 24);
    for (int t = 0; t < ntok; t++) begin
      kind = dense ? 0 : $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4: add_byte_seq(4);
        5: begin
          add_byte_seq($urandom_range(1, 3));
          add_ch(8'($urandom_range(0, 255)));
        end
        6: begin
          add_ch(hte_pkg::CH_SLASH);
          add_ch($urandom_range(0, 1) ? hex_ch() : 8'($urandom_range(0, 255)));
        end
        7: begin
          add_ch(hte_pkg::CH_SLASH);
          add_ch(hte_pkg::CH_SLASH);
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1)) begin
              add_byte_seq(4);
            end else begin
              c = 8'($urandom_range(0, 255));
              add_ch((c == hte_pkg::CH_CR || c == hte_pkg::CH_LF) ? CH_SPACE : c);
            end
          end
          add_ch($urandom_range(0, 1) ? hte_pkg::CH_CR : hte_pkg::CH_LF);
        end
        8: begin
          case ($urandom_range(0, 2))
            0: add_ch(hte_pkg::CH_CR);
            1: add_ch(hte_pkg::CH_LF);
            default: add_ch(CH_SPACE);
          endcase
        end
        default: add_ch(8'($urandom_range(0, 255)));
      endcase
    end
    // now and then a text runs on from the previous state, or has no end mark
    text_q[0].f = dense || ($urandom_range(0, 7) != 0);
    text_q[text_q.size() - 1].l = dense || ($urandom_range(0, 15) != 0);
  endtask

  function automatic void check_result();
    ext_result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: kind %0d value %0h index %0d count %0d",
             result_kind, byte_value, byte_index, total_count);
      errors++;
      return;
    end
    want = due_results.pop_front();
    if (result_kind !== want.kind) begin
      $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
      errors++;
    end
    if (byte_value !== want.value) begin
      $error("byte_value: expected %0h, got %0h", want.value, byte_value);
      errors++;
    end
    if (byte_index !== want.index) begin
      $error("byte_index: expected %0d, got %0d", want.index, byte_index);
      errors++;
    end
    if (total_count !== want.total) begin
      $error("total_count: expected %0d, got %0d", want.total, total_count);
      errors++;
    end
    if (overflow !== want.ovf) begin
      $error("overflow: expected %0d, got %0d", want.ovf, overflow);
      errors++;
    end
    if (last_result !== want.last) begin
      $error("last_result: expected %0d, got %0d", want.last, last_result);
      errors++;
    end
  endfunction

  // Result side: stall a random number of cycles before each transaction,
  // then hold ready until one is taken and check it.
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = pause_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result();
    end
  end

  // Hang detector: any transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : char_source
    int n_text;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed script; written-out rows replace the model's results
    foreach (script[i]) begin
      send_char(script[i].c, script[i].f, script[i].l, script[i].ntyped == 0);
      if (script[i].ntyped > 0) due_results.push_back(script[i].e0);
      if (script[i].ntyped > 1) due_results.push_back(script[i].e1);
    end
    drain_results();

    // random texts; the third one fills the table
    n_text = 0;
    while (items_sent < ITEMS_TARGET) begin
      steady_run = ($urandom_range(0, 5) == 0);
      build_text(n_text == 2);
      foreach (text_q[i]) send_char(text_q[i].c, text_q[i].f, text_q[i].l, 1'b1);
      if ($urandom_range(0, 5) == 0) drain_results();
      n_text++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    // catch anything extra trailing out of the pipeline
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
